### rtl/etfs_pkg.sv
// ----------------------------------------------------------------------------
// etfs_pkg
// Shared types, sizes and helpers for the ethertype frame statistics block.
// ----------------------------------------------------------------------------
package etfs_pkg;

    // Table and counter sizing
    localparam int TABLE_ENTRIES = 16;
    localparam int COUNT_BITS    = 32;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);

    // Fixed field widths of the channels
    localparam int KEY_W   = 16;
    localparam int OUT_W   = 32;
    localparam int SLOT_W  = 4;

    // Types at or above this value are Ethernet II
    localparam logic [KEY_W-1:0] ETHERNET2_MIN = 16'h0600;

    // Frame kind codes
    localparam logic KIND_ETHERNET2 = 1'b0;
    localparam logic KIND_IEEE8023  = 1'b1;

    // Front-to-back queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef logic [COUNT_BITS-1:0] count_t;

    // One classified request waiting for the back end
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             is_e2;
    } item_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [KEY_W-1:0] key;
        count_t           count;
    } entry_t;

    // One result as presented on the output channel
    typedef struct packed {
        logic              frame_kind;
        logic [OUT_W-1:0]  ethernet2_total;
        logic [OUT_W-1:0]  ieee8023_total;
        logic [SLOT_W-1:0] type_slot;
        logic [OUT_W-1:0]  type_count;
        logic              table_full;
    } result_t;

    // Back end sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } back_state_t;

    // Saturating increment
    function automatic count_t sat_inc(input count_t v);
        sat_inc = (v == '1) ? v : v + count_t'(1);
    endfunction

    // Low output bits of a counter
    function automatic logic [OUT_W-1:0] to_out(input count_t v);
        to_out = OUT_W'(v);
    endfunction

endpackage

### rtl/etfs_ram.sv
// ----------------------------------------------------------------------------
// etfs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module etfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/etfs_front.sv
// ----------------------------------------------------------------------------
// etfs_front
// Accepts type/length requests, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
module etfs_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [etfs_pkg::KEY_W-1:0]    s_type_length,
    output logic                          q_valid,
    output etfs_pkg::item_t               q_item,
    input  logic                          q_pop
);

    etfs_pkg::item_t                  slot_reg [etfs_pkg::QUEUE_DEPTH];
    logic [etfs_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [etfs_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [etfs_pkg::QPTR_W:0]        fill_reg, fill_next;
    logic                             push;
    etfs_pkg::item_t                  in_item;

    // Classify the incoming request
    always_comb begin
        in_item.key   = s_type_length;
        in_item.is_e2 = (s_type_length >= etfs_pkg::ETHERNET2_MIN);
    end

    assign s_ready = (fill_reg != (etfs_pkg::QPTR_W + 1)'(etfs_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (fill_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (!push && q_pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the request
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### rtl/etfs_back.sv
// ----------------------------------------------------------------------------
// etfs_back
// Updates the frame totals, scans the type table for Ethernet II requests and
// builds one result per request. The table is a RAM, scanned one entry per cycle.
// ----------------------------------------------------------------------------
module etfs_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  etfs_pkg::item_t      q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output etfs_pkg::result_t    m_result
);

    etfs_pkg::back_state_t           state_reg, state_next;
    logic [etfs_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [etfs_pkg::USED_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                            pend_reg, pend_next;
    logic [etfs_pkg::IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [etfs_pkg::USED_W-1:0]     used_reg, used_next;
    etfs_pkg::count_t                e2_tot_reg, e2_tot_next;
    etfs_pkg::count_t                ie_tot_reg, ie_tot_next;
    etfs_pkg::result_t               res_reg, res_next;
    logic                            m_valid_reg, m_valid_next;

    logic                            ram_wr_en;
    logic [etfs_pkg::IDX_W-1:0]      ram_wr_addr;
    etfs_pkg::entry_t                ram_wr_data;
    logic                            ram_rd_en;
    logic [etfs_pkg::IDX_W-1:0]      ram_rd_addr;
    etfs_pkg::entry_t                ram_rd_data;
    etfs_pkg::count_t                hit_count;

    etfs_ram #(
        .WIDTH ($bits(etfs_pkg::entry_t)),
        .DEPTH (etfs_pkg::TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign hit_count = etfs_pkg::sat_inc(ram_rd_data.count);

    // Sequence: pop a request, scan the table for Ethernet II, load the result
    always_comb begin
        state_next    = state_reg;
        key_next      = key_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        used_next     = used_reg;
        e2_tot_next   = e2_tot_reg;
        ie_tot_next   = ie_tot_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        q_pop         = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = pend_idx_reg;
        ram_wr_data   = '{key: key_reg, count: hit_count};
        ram_rd_en     = 1'b0;
        ram_rd_addr   = rd_idx_reg[etfs_pkg::IDX_W-1:0];

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            etfs_pkg::ST_IDLE: begin
                if (q_valid && !m_valid_reg) begin
                    q_pop = 1'b1;
                    if (q_item.is_e2) begin
                        e2_tot_next = etfs_pkg::sat_inc(e2_tot_reg);
                        key_next    = q_item.key;
                        rd_idx_next = '0;
                        pend_next   = 1'b0;
                        state_next  = etfs_pkg::ST_SCAN;
                    end else begin
                        ie_tot_next              = etfs_pkg::sat_inc(ie_tot_reg);
                        res_next.frame_kind      = etfs_pkg::KIND_IEEE8023;
                        res_next.ethernet2_total = etfs_pkg::to_out(e2_tot_reg);
                        res_next.ieee8023_total  = etfs_pkg::to_out(ie_tot_next);
                        res_next.type_slot       = '0;
                        res_next.type_count      = '0;
                        res_next.table_full      = 1'b0;
                        m_valid_next             = 1'b1;
                    end
                end
            end
            etfs_pkg::ST_SCAN: begin
                // Issue the next read while entries remain
                if (rd_idx_reg < used_reg) begin
                    ram_rd_en     = 1'b1;
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[etfs_pkg::IDX_W-1:0];
                end else begin
                    pend_next = 1'b0;
                end

                res_next.frame_kind      = etfs_pkg::KIND_ETHERNET2;
                res_next.ethernet2_total = etfs_pkg::to_out(e2_tot_reg);
                res_next.ieee8023_total  = etfs_pkg::to_out(ie_tot_reg);

                if (pend_reg && (ram_rd_data.key == key_reg)) begin
                    // Hit: bump the entry count
                    ram_wr_en           = 1'b1;
                    res_next.type_slot  = etfs_pkg::SLOT_W'(pend_idx_reg);
                    res_next.type_count = etfs_pkg::to_out(hit_count);
                    res_next.table_full = 1'b0;
                    m_valid_next        = 1'b1;
                    state_next          = etfs_pkg::ST_IDLE;
                end else if (!pend_reg && (rd_idx_reg >= used_reg)) begin
                    // Miss: allocate a free entry or flag a full table
                    if (used_reg < etfs_pkg::USED_W'(etfs_pkg::TABLE_ENTRIES)) begin
                        ram_wr_en           = 1'b1;
                        ram_wr_addr         = used_reg[etfs_pkg::IDX_W-1:0];
                        ram_wr_data         = '{key: key_reg, count: etfs_pkg::count_t'(1)};
                        used_next           = used_reg + 1'b1;
                        res_next.type_slot  = etfs_pkg::SLOT_W'(used_reg);
                        res_next.type_count = etfs_pkg::OUT_W'(1);
                        res_next.table_full = 1'b0;
                    end else begin
                        res_next.type_slot  = '0;
                        res_next.type_count = '0;
                        res_next.table_full = 1'b1;
                    end
                    m_valid_next = 1'b1;
                    state_next   = etfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = etfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= etfs_pkg::ST_IDLE;
            pend_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            used_reg    <= '0;
            e2_tot_reg  <= '0;
            ie_tot_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            rd_idx_reg  <= rd_idx_next;
            used_reg    <= used_next;
            e2_tot_reg  <= e2_tot_next;
            ie_tot_reg  <= ie_tot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = res_reg;

endmodule

### rtl/ethertype_frame_statistics.sv
// ----------------------------------------------------------------------------
// ethertype_frame_statistics
// Counts Ethernet II and 802.3 frames and keeps per-ethertype counts in a
// table of seen types.
//
//   Channel  Direction  Handshake           Payload
//   s_       in         s_valid / s_ready   type_length
//   m_       out        m_valid / m_ready   frame kind, totals, slot, count, full
//
// An 802.3 request gives its result in the cycle after it leaves the queue.
// An Ethernet II request scans the table in the back end, where the table RAM
// has one read port, scanned one entry per cycle. A two-deep queue keeps taking
// requests while a result waits. Reset is synchronous, active low, and empties
// the table at once.
// ----------------------------------------------------------------------------
module ethertype_frame_statistics (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [etfs_pkg::KEY_W-1:0]    s_type_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_frame_kind,
    output logic [etfs_pkg::OUT_W-1:0]    m_ethernet2_total,
    output logic [etfs_pkg::OUT_W-1:0]    m_ieee8023_total,
    output logic [etfs_pkg::SLOT_W-1:0]   m_type_slot,
    output logic [etfs_pkg::OUT_W-1:0]    m_type_count,
    output logic                          m_table_full
);

    logic                 q_valid;
    logic                 q_pop;
    etfs_pkg::item_t      q_item;
    etfs_pkg::result_t    result;

    // Accept and classify
    etfs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_type_length (s_type_length),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // Count and look up
    etfs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_frame_kind      = result.frame_kind;
    assign m_ethernet2_total = result.ethernet2_total;
    assign m_ieee8023_total  = result.ieee8023_total;
    assign m_type_slot       = result.type_slot;
    assign m_type_count      = result.type_count;
    assign m_table_full      = result.table_full;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ethertype_frame_statistics. A directed table covers
// the 802.3 / Ethernet II boundary, field extremes, table allocation and the
// table-full case. Random type/length requests follow under several idle and
// backpressure patterns. Results are checked against an in-bench model of the
// totals and ethertype table, or the hand-written result of a directed row.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int PHASE_REQUESTS  = 126;

    // Idle patterns of the random part
    typedef enum int {
        PH_STEADY,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE,
        PH_BACKPRESSURE
    } traffic_phase_t;

    // One result as seen on the m_ channel
    typedef struct packed {
        logic                        kind;
        logic [etfs_pkg::OUT_W-1:0]  e2_total;
        logic [etfs_pkg::OUT_W-1:0]  ieee_total;
        logic [etfs_pkg::SLOT_W-1:0] slot;
        logic [etfs_pkg::OUT_W-1:0]  count;
        logic                        full;
    } frame_stats_t;

    // One directed request, with a hand-written result where it is obvious
    typedef struct packed {
        logic [etfs_pkg::KEY_W-1:0] type_length;
        logic                       typed;
        frame_stats_t               want;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 24;

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // smallest and largest 802.3 lengths
        '{16'h0000, 1'b1, '{etfs_pkg::KIND_IEEE8023,  32'd0, 32'd1, 4'd0, 32'd0, 1'b0}},
        '{16'h05FF, 1'b1, '{etfs_pkg::KIND_IEEE8023,  32'd0, 32'd2, 4'd0, 32'd0, 1'b0}},
        // 0x06xx range is Ethernet II only
        '{16'h0600, 1'b1, '{etfs_pkg::KIND_ETHERNET2, 32'd1, 32'd2, 4'd0, 32'd1, 1'b0}},
        '{16'h06FF, 1'b1, '{etfs_pkg::KIND_ETHERNET2, 32'd2, 32'd2, 4'd1, 32'd1, 1'b0}},
        '{16'hFFFF, 1'b1, '{etfs_pkg::KIND_ETHERNET2, 32'd3, 32'd2, 4'd2, 32'd1, 1'b0}},
        // repeat hits the first entry
        '{16'h0600, 1'b1, '{etfs_pkg::KIND_ETHERNET2, 32'd4, 32'd2, 4'd0, 32'd2, 1'b0}},
        // fill the remaining entries
        '{16'h0800, 1'b0, '0},
        '{16'h0806, 1'b0, '0},
        '{16'h86DD, 1'b0, '0},
        '{16'h8100, 1'b0, '0},
        '{16'h88A8, 1'b0, '0},
        '{16'h8847, 1'b0, '0},
        '{16'h88CC, 1'b0, '0},
        '{16'h88E5, 1'b0, '0},
        '{16'h88F7, 1'b0, '0},
        '{16'h0842, 1'b0, '0},
        '{16'h22F0, 1'b0, '0},
        '{16'h9000, 1'b0, '0},
        '{16'h8035, 1'b0, '0},
        // new type on a full table is flagged, not stored
        '{16'h1234, 1'b1, '{etfs_pkg::KIND_ETHERNET2, 32'd18, 32'd2, 4'd0, 32'd0, 1'b1}},
        '{16'hFFFF, 1'b0, '0},
        '{16'h0601, 1'b1, '{etfs_pkg::KIND_ETHERNET2, 32'd20, 32'd2, 4'd0, 32'd0, 1'b1}},
        '{16'h05FE, 1'b0, '0},
        // hit on the last entry
        '{16'h8035, 1'b0, '0}
    };

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [etfs_pkg::KEY_W-1:0]   s_type_length;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_frame_kind;
    logic [etfs_pkg::OUT_W-1:0]   m_ethernet2_total;
    logic [etfs_pkg::OUT_W-1:0]   m_ieee8023_total;
    logic [etfs_pkg::SLOT_W-1:0]  m_type_slot;
    logic [etfs_pkg::OUT_W-1:0]   m_type_count;
    logic                         m_table_full;

    // Model state: totals and the table of seen ethertypes
    etfs_pkg::count_t             e2_frames;
    etfs_pkg::count_t             ieee_frames;
    logic [etfs_pkg::KEY_W-1:0]   seen_type  [etfs_pkg::TABLE_ENTRIES];
    etfs_pkg::count_t             seen_count [etfs_pkg::TABLE_ENTRIES];
    int                           types_used;

    frame_stats_t       pending_stats [$];
    int                 mismatch_count = 0;
    int                 result_count   = 0;
    int                 quiet_cycles   = 0;
    int                 sender_idle_pct    = 0;
    int                 receiver_stall_pct = 0;
    int                 hold_requests      = 0;

    ethertype_frame_statistics dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_type_length     (s_type_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_kind      (m_frame_kind),
        .m_ethernet2_total (m_ethernet2_total),
        .m_ieee8023_total  (m_ieee8023_total),
        .m_type_slot       (m_type_slot),
        .m_type_count      (m_type_count),
        .m_table_full      (m_table_full)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hold a counter at its maximum
    function automatic etfs_pkg::count_t saturate_up(input etfs_pkg::count_t v);
        return (v == {etfs_pkg::COUNT_BITS{1'b1}}) ? v : v + etfs_pkg::count_t'(1);
    endfunction

    // Classify one frame and update totals and the ethertype table
    function automatic frame_stats_t classify_frame(input logic [etfs_pkg::KEY_W-1:0] key);
        frame_stats_t r;
        int           hit;
        r   = '0;
        hit = -1;
        if (key >= etfs_pkg::ETHERNET2_MIN) begin
            r.kind    = etfs_pkg::KIND_ETHERNET2;
            e2_frames = saturate_up(e2_frames);
            for (int i = 0; i < types_used; i++) begin
                if (hit < 0 && seen_type[i] == key) hit = i;
            end
            if (hit >= 0) begin
                seen_count[hit] = saturate_up(seen_count[hit]);
                r.slot  = etfs_pkg::SLOT_W'(hit);
                r.count = etfs_pkg::OUT_W'(seen_count[hit]);
            end else if (types_used < etfs_pkg::TABLE_ENTRIES) begin
                seen_type[types_used]  = key;
                seen_count[types_used] = etfs_pkg::count_t'(1);
                r.slot  = etfs_pkg::SLOT_W'(types_used);
                r.count = etfs_pkg::OUT_W'(1);
                types_used++;
            end else begin
                r.full = 1'b1;
            end
        end else begin
            r.kind      = etfs_pkg::KIND_IEEE8023;
            ieee_frames = saturate_up(ieee_frames);
        end
        r.e2_total   = etfs_pkg::OUT_W'(e2_frames);
        r.ieee_total = etfs_pkg::OUT_W'(ieee_frames);
        return r;
    endfunction

    // Mostly known types, then 802.3 lengths, boundaries and raw noise
    function automatic logic [etfs_pkg::KEY_W-1:0] pick_type_length();
        int r;
        r = $urandom_range(99);
        if (r < 50 && types_used > 0) return seen_type[$urandom_range(types_used - 1)];
        if (r < 65) begin
            return etfs_pkg::KEY_W'($urandom_range(etfs_pkg::ETHERNET2_MIN - 1));
        end
        if (r < 75) begin
            case ($urandom_range(5))
                0:       return 16'h0000;
                1:       return etfs_pkg::ETHERNET2_MIN - 1'b1;
                2:       return etfs_pkg::ETHERNET2_MIN;
                3:       return 16'h06FF;
                4:       return etfs_pkg::ETHERNET2_MIN + 1'b1;
                default: return 16'hFFFF;
            endcase
        end
        return etfs_pkg::KEY_W'($urandom);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [etfs_pkg::OUT_W-1:0] got,
                               input logic [etfs_pkg::OUT_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      result_count, name, got, want));
        end
    endtask

    // Offer one request, wait for acceptance, then record its expected result
    task automatic offer_frame(input logic [etfs_pkg::KEY_W-1:0] key, input logic typed,
                               input frame_stats_t typed_want);
        frame_stats_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_type_length <= key;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = classify_frame(key);
        if (typed) predicted = typed_want;
        pending_stats = {pending_stats, predicted};
    endtask

    // Sender side: reset, directed table, random phases, drain
    initial begin : sender_side
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_type_length = '0;
        e2_frames     = '0;
        ieee_frames   = '0;
        types_used    = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_ROWS[i]) begin
            offer_frame(DIRECTED_ROWS[i].type_length, DIRECTED_ROWS[i].typed,
                        DIRECTED_ROWS[i].want);
        end

        for (int ph = PH_STEADY; ph <= PH_BACKPRESSURE; ph++) begin
            case (traffic_phase_t'(ph))
                PH_STEADY:         begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                PH_SENDER_IDLE:    begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
                PH_RECEIVER_STALL: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
                PH_BOTH_IDLE:      begin sender_idle_pct = 35; receiver_stall_pct = 35; end
                default:           begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            endcase
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // keep offering while the receiver holds off
                if (traffic_phase_t'(ph) == PH_BACKPRESSURE && n % 42 == 0) begin
                    hold_requests++;
                end
                offer_frame(pick_type_length(), 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then let the back end settle
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_stats.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (pending_stats.size() != 0) begin
                report_mismatch($sformatf("%0d results never arrived", pending_stats.size()));
            end
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Receiver side: random stalls plus long hold-off bursts
    initial begin : receiver_side
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        frame_stats_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_stats.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", result_count));
            end else begin
                want = pending_stats.pop_front();
                check_field("frame_kind",      etfs_pkg::OUT_W'(m_frame_kind),
                            etfs_pkg::OUT_W'(want.kind));
                check_field("ethernet2_total", m_ethernet2_total, want.e2_total);
                check_field("ieee8023_total",  m_ieee8023_total,  want.ieee_total);
                check_field("type_slot",       etfs_pkg::OUT_W'(m_type_slot),
                            etfs_pkg::OUT_W'(want.slot));
                check_field("type_count",      m_type_count,      want.count);
                check_field("table_full",      etfs_pkg::OUT_W'(m_table_full),
                            etfs_pkg::OUT_W'(want.full));
            end
            result_count++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
